### hdl/rc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rc_pkg
// Shared types and constants of the radix converter: input and result word
// layouts, controller-to-datapath command and status bundles, and sizes.
// ----------------------------------------------------------------------------
package rc_pkg;

    localparam int ACC_WIDTH_DEF = 64;
    localparam int BASE_W        = 6;
    localparam int DIV_STEP      = 4;
    localparam int BUF_DEPTH     = 64;
    localparam int BUF_AW        = $clog2(BUF_DEPTH);
    localparam int CFG_IW        = 1;

    localparam logic [CFG_IW-1:0] REG_SOURCE_BASE = 1'b0;
    localparam logic [CFG_IW-1:0] REG_TARGET_BASE = 1'b1;

    localparam logic [BASE_W-1:0] SOURCE_BASE_RST = 6'd10;
    localparam logic [BASE_W-1:0] TARGET_BASE_RST = 6'd2;

    typedef struct packed {
        logic [7:0] in_char;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       out_error;
        logic       out_last;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic eval;
        logic acc;
        logic fin;
        logic div_go;
        logic dig_wr;
        logic rd;
        logic emit;
        logic emit_err;
    } t_cmd;

    typedef struct packed {
        logic need_acc;
        logic last;
        logic fin_err;
        logic div_done;
        logic more;
        logic ptr_zero;
    } t_sts;

endpackage
`default_nettype wire

### hdl/rc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rc_div
// Iterative restoring divider of the accumulator width by a six-bit base,
// retiring DIV_STEP quotient bits per cycle.
// ----------------------------------------------------------------------------
module rc_div
    import rc_pkg::*;
#(
    parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [ACC_WIDTH-1:0] i_dividend,
    input  wire logic [BASE_W-1:0]    i_divisor,
    output logic                      o_done,
    output logic [ACC_WIDTH-1:0]      o_quot,
    output logic [BASE_W-1:0]         o_rem
);

    localparam int ITER = (ACC_WIDTH + DIV_STEP - 1) / DIV_STEP;
    localparam int DW   = ITER * DIV_STEP;
    localparam int CW   = $clog2(ITER + 1);

    logic [DW-1:0]     r_q, n_q;
    logic [BASE_W-1:0] r_rem, n_rem;
    logic [CW-1:0]     r_cnt;

    always_comb begin
        logic [BASE_W:0] t;
        n_q   = r_q;
        n_rem = r_rem;
        for (int k = 0; k < DIV_STEP; k++) begin
            t   = {n_rem, n_q[DW-1]};
            n_q = {n_q[DW-2:0], 1'b0};
            if (t >= {1'b0, i_divisor}) begin
                t      = t - {1'b0, i_divisor};
                n_q[0] = 1'b1;
            end
            n_rem = t[BASE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(ITER);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= DW'(i_dividend);
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_done = (r_cnt == '0);
    assign o_quot = r_q[ACC_WIDTH-1:0];
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

### hdl/rc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rc_ctrl
// Controller state machine: sequences character evaluation, accumulation,
// the digit-by-digit conversion and the readout of the digit buffer.
// ----------------------------------------------------------------------------
module rc_ctrl
    import rc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd,
    output logic      o_busy
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_CHAR = 7'b0000010,
        S_ACC  = 7'b0000100,
        S_FIN  = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_RD   = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHAR;
                end
            end
            S_CHAR: begin
                o_cmd.eval = 1'b1;
                if (i_sts.need_acc) begin
                    n_state = S_ACC;
                end else if (i_sts.last) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_sts.last ? S_FIN : S_IDLE;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                if (i_sts.fin_err) begin
                    o_cmd.emit_err = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.div_go = 1'b1;
                    n_state      = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.dig_wr = 1'b1;
                    if (i_sts.more) begin
                        o_cmd.div_go = 1'b1;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_OUT;
            end
            S_OUT: begin
                o_cmd.emit = 1'b1;
                n_state    = i_sts.ptr_zero ? S_IDLE : S_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule
`default_nettype wire

### hdl/rc_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rc_dpath
// Datapath: base registers, character decode, multiply-accumulate with
// overflow detection, divider, digit buffer and the registered result word.
// ----------------------------------------------------------------------------
module rc_dpath
    import rc_pkg::*;
#(
    parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    input  wire t_in_item          i_item,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_IW-1:0] i_cfg_index,
    input  wire logic [BASE_W-1:0] i_cfg_data,
    output t_sts                   o_sts,
    output logic                   o_strobe,
    output t_out_item              o_result
);

    localparam int PW = ACC_WIDTH + BASE_W;

    localparam logic [7:0] ASCII_0    = 8'h30;
    localparam logic [7:0] ASCII_9    = 8'h39;
    localparam logic [7:0] ASCII_UA   = 8'h41;
    localparam logic [7:0] ASCII_UZ   = 8'h5A;
    localparam logic [7:0] ASCII_LA   = 8'h61;
    localparam logic [7:0] ASCII_LZ   = 8'h7A;
    localparam logic [7:0] ASCII_PLUS = 8'h2B;
    localparam logic [BASE_W-1:0] MAX_BASE = 6'd36;

    // Bit 6 flags an alphanumeric character, bits 5:0 hold its digit value.
    function automatic logic [BASE_W:0] char_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= ASCII_0 && c <= ASCII_9) begin
            d = c - ASCII_0;
            return {1'b1, d[BASE_W-1:0]};
        end else if (c >= ASCII_LA && c <= ASCII_LZ) begin
            d = c - ASCII_LA + 8'd10;
            return {1'b1, d[BASE_W-1:0]};
        end else if (c >= ASCII_UA && c <= ASCII_UZ) begin
            d = c - ASCII_UA + 8'd10;
            return {1'b1, d[BASE_W-1:0]};
        end
        return '0;
    endfunction

    logic [BASE_W-1:0]    r_sb, r_tb;
    logic [7:0]           r_char;
    logic                 r_last;
    logic [ACC_WIDTH-1:0] r_acc;
    logic                 r_sign, r_err, r_cnz;
    logic [PW-1:0]        r_prod;
    logic [BASE_W-1:0]    r_v;
    logic [BUF_AW-1:0]    r_wa, r_ptr;
    logic [BASE_W-1:0]    r_mem [BUF_DEPTH];
    logic [BASE_W-1:0]    r_rd;
    logic                 r_strobe;
    t_out_item            r_res;

    logic                 bases_ok, nz, is_plus, dig_ok, need_acc;
    logic [BASE_W:0]      cv;
    logic [PW-1:0]        sum;
    logic                 div_done;
    logic [ACC_WIDTH-1:0] quot;
    logic [BASE_W-1:0]    rem;
    logic [7:0]           dig_char;

    assign bases_ok = (r_tb >= 6'd2) && (r_tb <= r_sb) && (r_sb <= MAX_BASE);
    assign nz       = (r_char != 8'd0);
    assign is_plus  = (r_char == ASCII_PLUS);
    assign cv       = char_value(r_char);
    assign dig_ok   = cv[BASE_W] && (cv[BASE_W-1:0] < r_sb);
    assign need_acc = nz && bases_ok && !(is_plus && r_sign) && dig_ok && !r_err;
    assign sum      = r_prod + PW'(r_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sb <= SOURCE_BASE_RST;
            r_tb <= TARGET_BASE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SOURCE_BASE: r_sb <= i_cfg_data;
                REG_TARGET_BASE: r_tb <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_sign <= 1'b1;
            r_err  <= 1'b0;
            r_cnz  <= 1'b0;
            r_wa   <= '0;
            r_ptr  <= '0;
        end else if (i_cmd.fin) begin
            r_acc  <= '0;
            r_sign <= 1'b1;
            r_err  <= 1'b0;
            r_cnz  <= 1'b0;
            r_wa   <= '0;
        end else if (i_cmd.eval) begin
            if (nz) begin
                r_cnz  <= 1'b1;
                r_sign <= 1'b0;
                if (!bases_ok) begin
                    r_err <= 1'b1;
                end else if (!(is_plus && r_sign) && !dig_ok) begin
                    r_err <= 1'b1;
                end
            end
        end else if (i_cmd.acc) begin
            if (sum[PW-1:ACC_WIDTH] != '0) begin
                r_err <= 1'b1;
            end else begin
                r_acc <= sum[ACC_WIDTH-1:0];
            end
        end else if (i_cmd.dig_wr) begin
            r_ptr <= r_wa;
            r_wa  <= r_wa + 1'b1;
        end else if (i_cmd.emit) begin
            r_ptr <= r_ptr - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_char <= i_item.in_char;
            r_last <= i_item.in_last;
        end
        if (i_cmd.eval) begin
            r_prod <= PW'(r_acc) * PW'(r_sb);
            r_v    <= cv[BASE_W-1:0];
        end
    end

    rc_div #(
        .ACC_WIDTH(ACC_WIDTH)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.div_go),
        .i_dividend(i_cmd.fin ? r_acc : quot),
        .i_divisor (r_tb),
        .o_done    (div_done),
        .o_quot    (quot),
        .o_rem     (rem)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.dig_wr) begin
            r_mem[r_wa] <= rem;
        end
        if (i_cmd.rd) begin
            r_rd <= r_mem[r_ptr];
        end
    end

    assign dig_char = (r_rd < 6'd10) ? (ASCII_0 + 8'(r_rd))
                                     : (ASCII_UA + 8'(r_rd) - 8'd10);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit || i_cmd.emit_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_err) begin
            r_res <= '{out_char: 8'd0, out_error: 1'b1, out_last: 1'b1};
        end else if (i_cmd.emit) begin
            r_res <= '{out_char: dig_char, out_error: 1'b0, out_last: (r_ptr == '0)};
        end
    end

    assign o_sts.need_acc = need_acc;
    assign o_sts.last     = r_last;
    assign o_sts.fin_err  = r_err || !r_cnz || !bases_ok;
    assign o_sts.div_done = div_done;
    assign o_sts.more     = (quot != '0) && (r_wa != '1);
    assign o_sts.ptr_zero = (r_ptr == '0);
    assign o_strobe       = r_strobe;
    assign o_result       = r_res;

endmodule
`default_nettype wire

### hdl/radix_converter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// radix_converter
// Each character is loaded and evaluated, then folded into the accumulator when it is accepted as a digit.
// On the last character, the shared divider produces each output digit by one
// division; the digits are then read back out of the digit buffer.
// The error word is raised from the finalize state after the last character.
// The receiver cannot stall; each word is shown for one cycle on o_strobe.
// Reset is synchronous: control clears, bases return to 10 and 2.
// ----------------------------------------------------------------------------
module radix_converter
    import rc_pkg::*;
#(
    parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire t_in_item          i_item,
    output logic                   o_strobe,
    output t_out_item              o_result,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [CFG_IW-1:0] i_cfg_index,
    input  wire logic [BASE_W-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = !busy;

    rc_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_sts  (sts),
        .o_cmd  (cmd),
        .o_busy (busy)
    );

    rc_dpath #(
        .ACC_WIDTH(ACC_WIDTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_sts      (sts),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");

    a_error_word_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.out_error |-> o_result.out_last && o_result.out_char == 8'd0)
        else $error("error word is not a lone final word");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.out_last |=> !o_strobe)
        else $error("word emitted right after the final word");
`endif

endmodule
`default_nettype wire
